// ===== design/tia_pkg.sv =====
// shared types, codes and width reduction for the typed integer alu
`default_nettype none

package tia_pkg;

    typedef enum logic [3:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_AND      = 4'd3,
        KIND_OR       = 4'd4,
        KIND_XOR      = 4'd5,
        KIND_NEG      = 4'd6,
        KIND_ABS      = 4'd7,
        KIND_NOT      = 4'd8,
        KIND_SGN      = 4'd9,
        KIND_QUICKADD = 4'd10,
        KIND_INT      = 4'd11,
        KIND_FIX      = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        TYPE_BOOL  = 3'd0,
        TYPE_BYTE  = 3'd1,
        TYPE_SHORT = 3'd2,
        TYPE_INT   = 3'd3,
        TYPE_LONG  = 3'd4
    } type_t;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;

    // reduce a value to the width of its type
    function automatic logic [DATA_W-1:0] fit(logic [2:0] t, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        case (t)
            TYPE_BYTE:           r = {{(DATA_W-8){1'b0}}, v[7:0]};
            TYPE_SHORT:          r = {{(DATA_W-16){v[15]}}, v[15:0]};
            TYPE_BOOL, TYPE_INT: r = {{(DATA_W-32){v[31]}}, v[31:0]};
            default:             r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tia_op_if.sv =====
// request channel carrying one operation with its type and operands
`default_nettype none

interface tia_op_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [2:0]  type_code;
    logic [63:0] operand_a;
    logic [63:0] operand_b;

    modport source (output valid, output kind, output type_code,
                    output operand_a, output operand_b, input ready);
    modport sink (input valid, input kind, input type_code,
                  input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ===== design/tia_res_if.sv =====
// result channel carrying the wrapped value and its type
`default_nettype none

interface tia_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic [2:0]  result_type;

    modport source (output valid, output result, output result_type, input ready);
    modport sink (input valid, input result, input result_type, output ready);
endinterface

`default_nettype wire

// ===== design/typed_integer_alu_top.sv =====
// an accepted request passes the input, product and result registers in that order
// before result valid is raised; each stage can be held by the stage after it
// throughput: one request per cycle while results are taken; the 64-bit multiply is split
// into 32x32 partial products in the second stage and summed in the third
// each stage advances when the stage after it is empty or moving, so requests keep
// filling empty stages while a result waits to be taken
// reset clears the stage valid flags only; no pending requests survive reset
`default_nettype none

module typed_integer_alu_top (
    input  wire           clk,
    input  wire           rst_n,
    tia_op_if.sink        op,
    tia_res_if.source     res
);

    localparam int unsigned W = tia_pkg::DATA_W;
    localparam int unsigned H = tia_pkg::HALF_W;

    // stage enables
    logic s1_en;
    logic s2_en;
    logic s3_en;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    // stage 1: reduced operands
    logic [3:0]   s1_kind_reg,  s1_kind_next;
    logic [2:0]   s1_type_reg,  s1_type_next;
    logic [W-1:0] s1_a_reg,     s1_a_next;
    logic [W-1:0] s1_b_reg,     s1_b_next;

    // stage 2: non-multiply result and partial products
    logic [W-1:0] s2_r_reg,     s2_r_next;
    logic [2:0]   s2_rt_reg,    s2_rt_next;
    logic         s2_mul_reg,   s2_mul_next;
    logic [W-1:0] s2_pp_ll_reg, s2_pp_ll_next;
    logic [H-1:0] s2_pp_lh_reg, s2_pp_lh_next;
    logic [H-1:0] s2_pp_hl_reg, s2_pp_hl_next;

    // stage 3: result register
    logic [W-1:0] s3_r_reg,     s3_r_next;
    logic [2:0]   s3_rt_reg;

    logic [W-1:0] pp_lh_full;
    logic [W-1:0] pp_hl_full;
    logic         is_bool;
    logic [H-1:0] cross_sum;
    logic [W-1:0] mul_sum;

    assign s3_en    = !s3_valid_reg || res.ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign op.ready = s1_en;

    // stage 1 input reduction; type codes above long act as long
    always_comb
    begin
        if (op.type_code > tia_pkg::TYPE_LONG)
            s1_type_next = tia_pkg::TYPE_LONG;
        else
            s1_type_next = op.type_code;
        s1_kind_next = op.kind;
        s1_a_next    = tia_pkg::fit(s1_type_next, op.operand_a);
        s1_b_next    = tia_pkg::fit(s1_type_next, op.operand_b);
    end

    // stage 2 operation select
    always_comb
    begin
        is_bool     = (s1_type_reg == tia_pkg::TYPE_BOOL);
        s2_rt_next  = s1_type_reg;
        s2_mul_next = 1'b0;
        case (s1_kind_reg)
            tia_pkg::KIND_ADD:
            begin
                s2_r_next = is_bool ? (s1_a_reg | s1_b_reg) : (s1_a_reg + s1_b_reg);
            end
            tia_pkg::KIND_SUB:
            begin
                s2_r_next = is_bool ? (s1_a_reg ^ s1_b_reg) : (s1_a_reg - s1_b_reg);
            end
            tia_pkg::KIND_MUL:
            begin
                s2_r_next   = s1_a_reg & s1_b_reg;
                s2_mul_next = !is_bool;
            end
            tia_pkg::KIND_AND: s2_r_next = s1_a_reg & s1_b_reg;
            tia_pkg::KIND_OR:  s2_r_next = s1_a_reg | s1_b_reg;
            tia_pkg::KIND_XOR: s2_r_next = s1_a_reg ^ s1_b_reg;
            tia_pkg::KIND_NEG: s2_r_next = '0 - s1_a_reg;
            tia_pkg::KIND_ABS: s2_r_next = s1_a_reg[W-1] ? ('0 - s1_a_reg) : s1_a_reg;
            tia_pkg::KIND_NOT:
            begin
                if (is_bool)
                    s2_r_next = (s1_a_reg != '0) ? '0 : '1;
                else
                    s2_r_next = ~s1_a_reg;
            end
            tia_pkg::KIND_SGN:
            begin
                if (s1_a_reg == '0)
                    s2_r_next = '0;
                else if (s1_a_reg[W-1])
                    s2_r_next = '1;
                else
                    s2_r_next = {{(W-1){1'b0}}, 1'b1};
                s2_rt_next = tia_pkg::TYPE_INT;
            end
            tia_pkg::KIND_QUICKADD:
            begin
                // wrapping makes the reduced immediate equivalent to the full one
                if (is_bool)
                    s2_r_next = s1_a_reg ^ {W{s1_b_reg[0]}};
                else
                    s2_r_next = s1_a_reg + s1_b_reg;
            end
            default: s2_r_next = s1_a_reg;
        endcase
    end

    // low 64 bits of the product from three 32x32 partial products
    always_comb
    begin
        s2_pp_ll_next = {{H{1'b0}}, s1_a_reg[H-1:0]} * {{H{1'b0}}, s1_b_reg[H-1:0]};
        pp_lh_full    = {{H{1'b0}}, s1_a_reg[H-1:0]} * {{H{1'b0}}, s1_b_reg[W-1:H]};
        pp_hl_full    = {{H{1'b0}}, s1_a_reg[W-1:H]} * {{H{1'b0}}, s1_b_reg[H-1:0]};
        s2_pp_lh_next = pp_lh_full[H-1:0];
        s2_pp_hl_next = pp_hl_full[H-1:0];
    end

    // stage 3 product combine and final wrap
    always_comb
    begin
        cross_sum = s2_pp_lh_reg + s2_pp_hl_reg;
        mul_sum   = s2_pp_ll_reg + {cross_sum, {H{1'b0}}};
        s3_r_next = tia_pkg::fit(s2_rt_reg, s2_mul_reg ? mul_sum : s2_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= op.valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && op.valid)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_type_reg <= s1_type_next;
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_r_reg     <= s2_r_next;
            s2_rt_reg    <= s2_rt_next;
            s2_mul_reg   <= s2_mul_next;
            s2_pp_ll_reg <= s2_pp_ll_next;
            s2_pp_lh_reg <= s2_pp_lh_next;
            s2_pp_hl_reg <= s2_pp_hl_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_r_reg  <= s3_r_next;
            s3_rt_reg <= s2_rt_reg;
        end
    end

    assign res.valid       = s3_valid_reg;
    assign res.result      = s3_r_reg;
    assign res.result_type = s3_rt_reg;

`ifndef SYNTHESIS
    a_type_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.result_type <= tia_pkg::TYPE_LONG))
        else $error("result type above long");

    a_byte_zero_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_type == tia_pkg::TYPE_BYTE) |-> (res.result[W-1:8] == '0))
        else $error("byte result not zero-extended");

    a_short_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_type == tia_pkg::TYPE_SHORT)
            |-> (res.result[W-1:15] == '0 || res.result[W-1:15] == '1))
        else $error("short result not sign-extended");

    a_int_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.result_type == tia_pkg::TYPE_INT
                       || res.result_type == tia_pkg::TYPE_BOOL))
            |-> (res.result[W-1:31] == '0 || res.result[W-1:31] == '1))
        else $error("integer result not sign-extended");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_typed_integer_alu_top.sv =====
// testbench for the typed integer alu: directed rows, then random requests under varied idling
`default_nettype none

module tb_typed_integer_alu_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0]  KIND_UNUSED_LO  = 4'd13;
    localparam logic [3:0]  KIND_UNUSED_HI  = 4'd15;
    localparam logic [2:0]  TYPE_ALIAS_LO   = 3'd5;
    localparam logic [2:0]  TYPE_ALIAS_HI   = 3'd7;
    localparam logic [63:0] ALL_ONES        = {64{1'b1}};
    localparam logic [63:0] LONG_MIN        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LONG_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          HOLD_OFF_CYCLES = 60;
    localparam int          DRAIN_CYCLES    = 12;
    localparam int          DIRECTED_COUNT  = 26;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  tcode;
        logic [63:0] a;
        logic [63:0] b;
        logic        known;
        logic [63:0] want_value;
        logic [2:0]  want_type;
    } alu_request_t;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  rtype;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tia_op_if  op_ch ();
    tia_res_if res_ch ();

    typed_integer_alu_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    alu_result_t results_due [$];
    int          send_idle_pct     = 0;
    int          recv_stall_pct    = 0;
    int          hold_off_requests = 0;
    int          requests_issued   = 0;
    int          results_compared  = 0;
    int          mismatches        = 0;

    // rows with a typed-in value are read straight off the spec; the rest go through the predictor
    alu_request_t directed_rows [DIRECTED_COUNT] = '{
        '{tia_pkg::KIND_ADD, tia_pkg::TYPE_LONG, LONG_MAX, 64'd1,
          1'b1, LONG_MIN, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_SUB, tia_pkg::TYPE_BYTE, 64'd0, 64'd1,
          1'b1, 64'h0000_0000_0000_00FF, tia_pkg::TYPE_BYTE},
        '{tia_pkg::KIND_MUL, tia_pkg::TYPE_SHORT, 64'h7FFF, 64'd2,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFE, tia_pkg::TYPE_SHORT},
        '{tia_pkg::KIND_MUL, tia_pkg::TYPE_LONG, ALL_ONES, ALL_ONES,
          1'b1, 64'd1, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_MUL, tia_pkg::TYPE_LONG, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
          1'b0, 64'd0, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_ADD, tia_pkg::TYPE_BOOL, 64'd0, ALL_ONES,
          1'b1, ALL_ONES, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_MUL, tia_pkg::TYPE_BOOL, ALL_ONES, 64'd0,
          1'b1, 64'd0, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_AND, tia_pkg::TYPE_INT, 64'hFFFF_FFFF_F0F0_F0F0, 64'h0000_0000_FF00_FF00,
          1'b0, 64'd0, tia_pkg::TYPE_INT},
        '{tia_pkg::KIND_NEG, tia_pkg::TYPE_INT, 64'hFFFF_FFFF_8000_0000, 64'd0,
          1'b1, 64'hFFFF_FFFF_8000_0000, tia_pkg::TYPE_INT},
        '{tia_pkg::KIND_ABS, tia_pkg::TYPE_LONG, LONG_MIN, 64'd0,
          1'b1, LONG_MIN, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_ABS, tia_pkg::TYPE_BYTE, 64'hFF, 64'd0,
          1'b1, 64'hFF, tia_pkg::TYPE_BYTE},
        '{tia_pkg::KIND_NEG, tia_pkg::TYPE_BOOL, ALL_ONES, 64'd0,
          1'b1, 64'd1, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_NOT, tia_pkg::TYPE_BOOL, 64'd0, 64'd0,
          1'b1, ALL_ONES, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_NOT, tia_pkg::TYPE_BOOL, 64'd5, 64'd0,
          1'b1, 64'd0, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_SGN, tia_pkg::TYPE_LONG, LONG_MIN, 64'd0,
          1'b1, ALL_ONES, tia_pkg::TYPE_INT},
        '{tia_pkg::KIND_SGN, tia_pkg::TYPE_BYTE, 64'h80, 64'd0,
          1'b1, 64'd1, tia_pkg::TYPE_INT},
        '{tia_pkg::KIND_SGN, tia_pkg::TYPE_SHORT, 64'd0, 64'd0,
          1'b1, 64'd0, tia_pkg::TYPE_INT},
        '{tia_pkg::KIND_QUICKADD, tia_pkg::TYPE_BOOL, 64'd0, 64'd1,
          1'b1, ALL_ONES, tia_pkg::TYPE_BOOL},
        '{tia_pkg::KIND_QUICKADD, tia_pkg::TYPE_BYTE, 64'hFE, 64'hFFFF_FFFF_FFFF_0003,
          1'b1, 64'd1, tia_pkg::TYPE_BYTE},
        '{tia_pkg::KIND_QUICKADD, tia_pkg::TYPE_SHORT, 64'h7FFF, 64'd1,
          1'b1, 64'hFFFF_FFFF_FFFF_8000, tia_pkg::TYPE_SHORT},
        '{tia_pkg::KIND_INT, tia_pkg::TYPE_SHORT, 64'h1234_5678_0001_8000, 64'd0,
          1'b1, 64'hFFFF_FFFF_FFFF_8000, tia_pkg::TYPE_SHORT},
        '{tia_pkg::KIND_FIX, tia_pkg::TYPE_INT, 64'h0000_0001_7FFF_FFFF, 64'd0,
          1'b1, 64'h0000_0000_7FFF_FFFF, tia_pkg::TYPE_INT},
        '{KIND_UNUSED_LO, tia_pkg::TYPE_BYTE, 64'hABCD, 64'd0,
          1'b1, 64'hCD, tia_pkg::TYPE_BYTE},
        '{KIND_UNUSED_HI, tia_pkg::TYPE_LONG, ALL_ONES, 64'd0,
          1'b1, ALL_ONES, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_ADD, TYPE_ALIAS_LO, 64'd1, 64'd1,
          1'b1, 64'd2, tia_pkg::TYPE_LONG},
        '{tia_pkg::KIND_SGN, TYPE_ALIAS_HI, ALL_ONES, 64'd0,
          1'b1, ALL_ONES, tia_pkg::TYPE_INT}
    };

    function automatic logic [63:0] wrap_to_type(logic [2:0] t, logic [63:0] v);
        logic [63:0] w;
        case (t)
            tia_pkg::TYPE_BYTE:  w = {56'd0, v[7:0]};
            tia_pkg::TYPE_SHORT: w = {{48{v[15]}}, v[15:0]};
            tia_pkg::TYPE_BOOL,
            tia_pkg::TYPE_INT:   w = {{32{v[31]}}, v[31:0]};
            default:             w = v;
        endcase
        return w;
    endfunction

    function automatic alu_result_t compute_alu_result(logic [3:0] kind, logic [2:0] tcode,
                                                        logic [63:0] raw_a, logic [63:0] raw_b);
        alu_result_t out;
        logic [2:0]  t;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        // spare type codes behave as long
        t = (tcode > tia_pkg::TYPE_LONG) ? tia_pkg::TYPE_LONG : tcode;
        out.rtype = t;
        a = wrap_to_type(t, raw_a);
        b = wrap_to_type(t, raw_b);
        case (kind)
            tia_pkg::KIND_ADD:  r = (t == tia_pkg::TYPE_BOOL) ? (a | b) : (a + b);
            tia_pkg::KIND_SUB:  r = (t == tia_pkg::TYPE_BOOL) ? (a ^ b) : (a - b);
            tia_pkg::KIND_MUL:  r = (t == tia_pkg::TYPE_BOOL) ? (a & b) : (a * b);
            tia_pkg::KIND_AND:  r = a & b;
            tia_pkg::KIND_OR:   r = a | b;
            tia_pkg::KIND_XOR:  r = a ^ b;
            tia_pkg::KIND_NEG:  r = 64'd0 - a;
            tia_pkg::KIND_ABS:  r = a[63] ? (64'd0 - a) : a;
            tia_pkg::KIND_NOT:
            begin
                if (t == tia_pkg::TYPE_BOOL)
                    r = (a != 64'd0) ? 64'd0 : ALL_ONES;
                else
                    r = ~a;
            end
            tia_pkg::KIND_SGN:
            begin
                if (a == 64'd0)
                    r = 64'd0;
                else
                    r = a[63] ? ALL_ONES : 64'd1;
                out.rtype = tia_pkg::TYPE_INT;
            end
            tia_pkg::KIND_QUICKADD:
            begin
                // immediate is taken unreduced
                if (t == tia_pkg::TYPE_BOOL)
                    r = raw_b[0] ? ~a : a;
                else
                    r = a + raw_b;
            end
            default:   r = a;
        endcase
        out.value = wrap_to_type(out.rtype, r);
        return out;
    endfunction

    function automatic logic [63:0] type_extreme(logic [2:0] t, bit high);
        logic [63:0] v;
        case (t)
            tia_pkg::TYPE_BYTE:  v = high ? 64'hFF : 64'd0;
            tia_pkg::TYPE_SHORT: v = high ? 64'h7FFF : 64'hFFFF_FFFF_FFFF_8000;
            tia_pkg::TYPE_BOOL,
            tia_pkg::TYPE_INT:   v = high ? 64'h7FFF_FFFF : 64'hFFFF_FFFF_8000_0000;
            default:             v = high ? LONG_MAX : LONG_MIN;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] pick_operand(logic [2:0] t);
        logic [63:0] v;
        case ($urandom_range(7))
            0:       v = 64'd0;
            1:       v = 64'd1;
            2:       v = ALL_ONES;
            3:       v = type_extreme(t, 1'b0);
            4:       v = type_extreme(t, 1'b1);
            5:       v = 64'($urandom_range(32)) - 64'd16;
            default: v = {$urandom, $urandom};
        endcase
        // most operands arrive already reduced, the rest carry junk in the upper bits
        if ($urandom_range(4) != 0)
        begin
            v = wrap_to_type(t, v);
            if (t == tia_pkg::TYPE_BOOL && $urandom_range(1) == 1)
                v = ($urandom_range(1) == 1) ? ALL_ONES : 64'd0;
        end
        return v;
    endfunction

    function automatic alu_request_t make_random_request();
        alu_request_t rq;
        rq = '0;
        if ($urandom_range(9) == 0)
            rq.kind = 4'($urandom_range(int'(KIND_UNUSED_HI), int'(KIND_UNUSED_LO)));
        else
            rq.kind = 4'($urandom_range(int'(tia_pkg::KIND_FIX), int'(tia_pkg::KIND_ADD)));
        if ($urandom_range(9) == 0)
            rq.tcode = 3'($urandom_range(int'(TYPE_ALIAS_HI), int'(TYPE_ALIAS_LO)));
        else
            rq.tcode = 3'($urandom_range(int'(tia_pkg::TYPE_LONG), int'(tia_pkg::TYPE_BOOL)));
        rq.a = pick_operand(rq.tcode);
        rq.b = pick_operand(rq.tcode);
        return rq;
    endfunction

    task automatic drive_request(input alu_request_t rq);
        alu_result_t due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid     <= 1'b1;
        op_ch.kind      <= rq.kind;
        op_ch.type_code <= rq.tcode;
        op_ch.operand_a <= rq.a;
        op_ch.operand_b <= rq.b;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        if (rq.known)
        begin
            due.value = rq.want_value;
            due.rtype = rq.want_type;
        end
        else
        begin
            due = compute_alu_result(rq.kind, rq.tcode, rq.a, rq.b);
        end
        results_due.push_back(due);
        requests_issued++;
    endtask

    task automatic run_phase(input int count, input int sender_idle, input int receiver_stall);
        send_idle_pct = sender_idle;
        recv_stall_pct <= receiver_stall;
        repeat (count)
            drive_request(make_random_request());
    endtask

    initial
    begin : stimulus
        rst_n           = 1'b0;
        op_ch.valid     = 1'b0;
        op_ch.kind      = tia_pkg::KIND_ADD;
        op_ch.type_code = tia_pkg::TYPE_BOOL;
        op_ch.operand_a = 64'd0;
        op_ch.operand_b = 64'd0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_request(directed_rows[i]);

        run_phase(300, 0, 0);
        run_phase(300, 58, 0);
        run_phase(300, 0, 58);
        run_phase(300, 24, 24);

        // long output hold-off while requests keep coming, so the pipe backs up
        hold_off_requests <= hold_off_requests + 1;
        run_phase(50, 0, 0);

        op_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d requests over all operation and type codes, spare codes included;",
                 requests_issued);
        $display("%0d results compared under no, sender, receiver and mixed idling plus a hold-off",
                 results_compared);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_off_requests)
            begin
                hold_seen = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        alu_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result with no request pending: got %h type %0d",
                         $time, res_ch.result, res_ch.result_type);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                results_compared++;
                if (res_ch.result !== want.value)
                begin
                    $display("%0t: result mismatch: expected %h, got %h",
                             $time, want.value, res_ch.result);
                    mismatches++;
                end
                if (res_ch.result_type !== want.rtype)
                begin
                    $display("%0t: result_type mismatch: expected %0d, got %0d",
                             $time, want.rtype, res_ch.result_type);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
